FILE: sv/vbt_pkg.sv
// Shared constants, codes and types of the volume boundary taper.
package vbt_pkg;

   localparam int MAX_BOUND       = 64;
   localparam int MAX_DIM         = 4096;
   localparam int SAMPLE_BITS     = 24;
   localparam int TAPER_FRAC_BITS = 15;

   localparam int TAPER_BITS    = 16;
   localparam int SIZE_BITS     = 13;
   localparam int BOUND_BITS    = 7;
   localparam int POS_BITS      = $clog2(MAX_DIM);
   localparam int IDX_BITS      = $clog2(MAX_BOUND);
   localparam int AXIS_BITS     = 2;
   localparam int TAB_ADDR_BITS = AXIS_BITS + IDX_BITS;
   localparam int NUM_STEPS     = 6;
   localparam int STEP_BITS     = 3;
   localparam int CSR_IDX_BITS  = 3;

   // Factor of one in unsigned Q1.15
   localparam logic [TAPER_BITS-1:0] TAPER_ONE = TAPER_BITS'(1 << TAPER_FRAC_BITS);

   localparam logic [AXIS_BITS-1:0] AXIS_X    = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y    = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z    = 2'd2;
   localparam logic [AXIS_BITS-1:0] AXIS_NONE = 2'd3;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_X  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_Y  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_Z  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOUND_X = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOUND_Y = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOUND_Z = 3'd5;

   typedef struct packed {
      logic load;   // take a new sample
      logic mul;    // register sample times factor
      logic rnd;    // round, saturate and keep
   } vbt_ctl_type;

endpackage

FILE: sv/volume_boundary_taper.sv
// Volume boundary taper: 3D position tracking, taper tables and sequencer.
// rsp_tvalid rises once a sample request has passed six dependent multiply and round steps,
//   each a multiply state then a round state, on the shared scaling unit; a new sample is not
//   accepted until the previous result is registered. One table load per cycle while idle.
// Reset clears positions, sequencer and output valid and sets sizes to 1, bounds to 0.
// Taper table memory is not cleared by reset.
module volume_boundary_taper (
   input  logic        clock,
   input  logic        reset,
   // csr port
   input  logic        csr_we,
   input  logic [vbt_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [vbt_pkg::SIZE_BITS-1:0]    csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // table_index[5:0], taper_word[21:6], sample_in[45:22], zero
   input  logic [2:0]  req_tuser,   // opcode[0], table_axis[2:1]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample_out[23:0]
   output logic        rsp_tlast    // volume_end
);
   import vbt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_RND  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_STEPS - 1);

   typedef struct packed {
      logic                lo_hit;
      logic [IDX_BITS-1:0] lo_idx;
      logic                hi_hit;
      logic [IDX_BITS-1:0] hi_idx;
   } plan_type;

   // Configuration registers
   logic [SIZE_BITS-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [BOUND_BITS-1:0] bound_x_ff, bound_y_ff, bound_z_ff;

   // Position counters
   logic [POS_BITS-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_BITS-1:0] pos_x_in, pos_y_in, pos_z_in;

   // Sequencer
   logic [1:0]               state_ff, state_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [TAB_ADDR_BITS-1:0] step_addr_ff [NUM_STEPS];
   logic                     apply_ff [NUM_STEPS];
   logic                     end_ff, end_in;

   // Table memory
   logic [TAPER_BITS-1:0]    taper_mem [2**TAB_ADDR_BITS];
   logic [TAPER_BITS-1:0]    rd_data_ff;
   logic                     rd_en, wr_en;
   logic [TAB_ADDR_BITS-1:0] rd_addr, wr_addr;

   // Output register
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;
   logic                   rsp_last_ff;

   // Request fields
   logic                          req_fire, take_sample, take_load;
   logic [AXIS_BITS-1:0]          req_axis;
   logic [IDX_BITS-1:0]           req_index;
   logic [TAPER_BITS-1:0]         req_word;
   logic signed [SAMPLE_BITS-1:0] req_sample;

   logic [SIZE_BITS-1:0]     sx, sy, sz;
   plan_type                 plan_x, plan_y, plan_z;
   logic [TAB_ADDR_BITS-1:0] plan_addr [NUM_STEPS];
   logic                     plan_hit [NUM_STEPS];
   logic [STEP_BITS-1:0]     next_step;

   vbt_ctl_type                   scale_ctl;
   logic [TAPER_BITS-1:0]         scale_factor;
   logic signed [SAMPLE_BITS-1:0] scale_result;

   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > SIZE_BITS'(MAX_DIM)) begin
         r = SIZE_BITS'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic plan_type axis_plan(input logic [POS_BITS-1:0] pos,
                                          input logic [SIZE_BITS-1:0] size,
                                          input logic [BOUND_BITS-1:0] bound);
      plan_type             p;
      logic [SIZE_BITS-1:0] b;
      logic [SIZE_BITS-1:0] pos_w;
      logic [SIZE_BITS-1:0] hi_gap;
      b = (bound > BOUND_BITS'(MAX_BOUND)) ? SIZE_BITS'(MAX_BOUND)
                                            : SIZE_BITS'(bound);
      pos_w = SIZE_BITS'(pos);
      hi_gap = size - SIZE_BITS'(1) - pos_w;
      p.lo_hit = (pos_w < b);
      p.lo_idx = pos_w[IDX_BITS-1:0];
      // High face only applies while the position lies inside the volume
      p.hi_hit = (pos_w < size) && (hi_gap < b);
      p.hi_idx = hi_gap[IDX_BITS-1:0];
      return p;
   endfunction

   assign req_axis   = req_tuser[2:1];
   assign req_index  = req_tdata[5:0];
   assign req_word   = req_tdata[21:6];
   assign req_sample = $signed(req_tdata[45:22]);

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign take_sample = req_fire && (req_tuser[0] == OP_SAMPLE);
   assign take_load   = req_fire && (req_tuser[0] == OP_LOAD);

   assign sx = eff_size(size_x_ff);
   assign sy = eff_size(size_y_ff);
   assign sz = eff_size(size_z_ff);

   assign plan_x = axis_plan(pos_x_ff, sx, bound_x_ff);
   assign plan_y = axis_plan(pos_y_ff, sy, bound_y_ff);
   assign plan_z = axis_plan(pos_z_ff, sz, bound_z_ff);

   // Step order: y low, y high, x low, x high, z low, z high
   always_comb begin
      plan_addr[0] = {AXIS_Y, plan_y.lo_idx};  plan_hit[0] = plan_y.lo_hit;
      plan_addr[1] = {AXIS_Y, plan_y.hi_idx};  plan_hit[1] = plan_y.hi_hit;
      plan_addr[2] = {AXIS_X, plan_x.lo_idx};  plan_hit[2] = plan_x.lo_hit;
      plan_addr[3] = {AXIS_X, plan_x.hi_idx};  plan_hit[3] = plan_x.hi_hit;
      plan_addr[4] = {AXIS_Z, plan_z.lo_idx};  plan_hit[4] = plan_z.lo_hit;
      plan_addr[5] = {AXIS_Z, plan_z.hi_idx};  plan_hit[5] = plan_z.hi_hit;
   end

   // Advance the position counters, z fastest
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      end_in   = end_ff;
      if (take_sample) begin
         end_in = 1'b0;
         if ((SIZE_BITS'(pos_z_ff) + SIZE_BITS'(1)) < sz) begin
            pos_z_in = pos_z_ff + POS_BITS'(1);
         end else begin
            pos_z_in = '0;
            if ((SIZE_BITS'(pos_x_ff) + SIZE_BITS'(1)) < sx) begin
               pos_x_in = pos_x_ff + POS_BITS'(1);
            end else begin
               pos_x_in = '0;
               if ((SIZE_BITS'(pos_y_ff) + SIZE_BITS'(1)) < sy) begin
                  pos_y_in = pos_y_ff + POS_BITS'(1);
               end else begin
                  pos_y_in = '0;
                  end_in   = 1'b1;
               end
            end
         end
      end
   end

   assign next_step = step_ff + STEP_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      scale_ctl     = '0;
      rd_en         = 1'b0;
      rd_addr       = plan_addr[0];
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (take_sample) begin
               scale_ctl.load = 1'b1;
               rd_en          = 1'b1;
               step_in        = '0;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            scale_ctl.mul = 1'b1;
            // Fetch the next factor while this step finishes
            if (step_ff != LAST_STEP) begin
               rd_en   = 1'b1;
               rd_addr = step_addr_ff[next_step];
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            scale_ctl.rnd = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end else begin
               step_in  = next_step;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign scale_factor = apply_ff[step_ff] ? rd_data_ff : TAPER_ONE;

   assign wr_en   = take_load && (req_axis != AXIS_NONE);
   assign wr_addr = {req_axis, req_index};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         taper_mem[wr_addr] <= req_word;
      end
      if (rd_en) begin
         rd_data_ff <= taper_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= SIZE_BITS'(1);
         size_y_ff  <= SIZE_BITS'(1);
         size_z_ff  <= SIZE_BITS'(1);
         bound_x_ff <= '0;
         bound_y_ff <= '0;
         bound_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SIZE_X:  size_x_ff  <= csr_wdata;
            REG_SIZE_Y:  size_y_ff  <= csr_wdata;
            REG_SIZE_Z:  size_z_ff  <= csr_wdata;
            REG_BOUND_X: bound_x_ff <= csr_wdata[BOUND_BITS-1:0];
            REG_BOUND_Y: bound_y_ff <= csr_wdata[BOUND_BITS-1:0];
            REG_BOUND_Z: bound_z_ff <= csr_wdata[BOUND_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
         end_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         pos_z_ff      <= pos_z_in;
         end_ff        <= end_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         for (int i = 0; i < NUM_STEPS; i++) begin
            step_addr_ff[i] <= plan_addr[i];
            apply_ff[i]     <= plan_hit[i];
         end
      end
      if ((state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_data_ff <= scale_result;
         rsp_last_ff <= end_ff;
      end
   end

   vbt_scale u_scale (
      .clock  (clock),
      .ctl    (scale_ctl),
      .sample (req_sample),
      .factor (scale_factor),
      .result (scale_result)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> (state_ff == ST_MUL) && (step_ff == '0))
      else $error("sample accepted without starting the sequence");

   a_load_holds_pos: assert property (@(posedge clock) disable iff (reset)
      take_load |=> $stable(pos_x_ff) && $stable(pos_y_ff) && $stable(pos_z_ff))
      else $error("table load moved the position counters");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= LAST_STEP))
      else $error("step counter out of range");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside the output state");

   a_no_wr_while_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE) && !rd_en)
      else $error("table write overlaps a sequence");

endmodule

FILE: sv/vbt_scale.sv
// Fixed-point scaling unit: registered multiply, then round and saturate.
module vbt_scale (
   input  logic                                 clock,
   input  vbt_pkg::vbt_ctl_type                 ctl,
   input  logic signed [vbt_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [vbt_pkg::TAPER_BITS-1:0]       factor,
   output logic signed [vbt_pkg::SAMPLE_BITS-1:0] result
);
   import vbt_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + TAPER_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int Q_BITS    = SUM_BITS - TAPER_FRAC_BITS;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
      SUM_BITS'(1 << (TAPER_FRAC_BITS - 1));
   localparam logic signed [Q_BITS-1:0] SAT_HI = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_BITS-1:0] SAT_LO = -SAT_HI - Q_BITS'(1);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [SUM_BITS-1:0]    sum;
   logic signed [Q_BITS-1:0]      quot;

   // Arithmetic right shift of the rounded product gives floor division
   assign sum  = SUM_BITS'(prod_ff) + ROUND_HALF;
   assign quot = sum[SUM_BITS-1:TAPER_FRAC_BITS];

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = sample;
      end else if (ctl.rnd) begin
         if (quot > SAT_HI) begin
            value_in = SAT_HI[SAMPLE_BITS-1:0];
         end else if (quot < SAT_LO) begin
            value_in = SAT_LO[SAMPLE_BITS-1:0];
         end else begin
            value_in = quot[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctl.mul) begin
         prod_ff <= PROD_BITS'(value_ff * $signed({1'b0, factor}));
      end
   end

   assign result = value_ff;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for volume_boundary_taper: directed table, then random phases checked by a local predictor.
module tb_top;
   import vbt_pkg::*;

   localparam int NUM_REGS      = 6;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 105;
   localparam int HOLD_PHASE    = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 10;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic                   op;
      logic [AXIS_BITS-1:0]   axis;
      logic [IDX_BITS-1:0]    idx;
      logic [TAPER_BITS-1:0]  word;
      logic [SAMPLE_BITS-1:0] smp;
   } taper_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smp;
      logic                   last;
   } taper_res_type;

   typedef struct {
      row_kind_type            kind;
      taper_req_type           req;
      logic                    typed_exp;
      taper_res_type           res;
      logic [CSR_IDX_BITS-1:0] csr_idx;
      logic [SIZE_BITS-1:0]    csr_val;
   } stim_row_type;

   // size_x, size_y, size_z, bound_x, bound_y, bound_z
   int unsigned phase_cfg [NUM_PHASES][NUM_REGS] = '{
      '{4, 3, 6, 2, 1, 3},
      '{2, 2, 2, 64, 64, 64},
      '{0, 0, 7, 0, 0, 127},
      '{5, 4, 3, 3, 2, 2},
      '{8191, 1, 4096, 64, 0, 64},
      '{3, 2, 9, 1, 1, 4},
      '{1, 1, 1, 127, 127, 127},
      '{7, 5, 2, 4, 3, 1},
      '{2, 3, 130, 1, 2, 64},
      '{6, 6, 6, 5, 5, 5},
      '{4096, 2, 1, 64, 1, 64},
      '{3, 3, 3, 2, 2, 2}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [SIZE_BITS-1:0]    csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [47:0]             req_tdata = '0;   // table_index, taper_word, sample_in, zero
   logic [2:0]              req_tuser = '0;   // opcode, table_axis
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [23:0]             rsp_tdata;        // sample_out
   logic                    rsp_tlast;

   // predictor state
   logic [TAPER_BITS-1:0] taper_mem [3][MAX_BOUND];
   int unsigned           cfg_reg [NUM_REGS];
   int unsigned           pos_x, pos_y, pos_z;
   taper_res_type         pending_samples [$];

   int            mismatches = 0;
   int            quiet_cycles = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   logic          hold_go = 1'b0;
   logic          hold_taken = 1'b0;
   int            hold_left = 0;
   logic          req_moved = 1'b0;

   volume_boundary_taper u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_dim(input int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // multiply by a Q1.15 factor, round halves upwards, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] scale_by(
      input logic signed [SAMPLE_BITS-1:0] s, input logic [TAPER_BITS-1:0] f);
      longint p;
      p = longint'(s) * longint'(f) + (longint'(1) <<< (TAPER_FRAC_BITS - 1));
      p = p >>> TAPER_FRAC_BITS;
      if (p > longint'(SAMPLE_MAX)) p = longint'(SAMPLE_MAX);
      if (p < longint'(SAMPLE_MIN)) p = longint'(SAMPLE_MIN);
      return p[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] taper_one_axis(
      input logic signed [SAMPLE_BITS-1:0] s, input logic [AXIS_BITS-1:0] ax,
      input int unsigned p, input int unsigned sz, input int unsigned bnd);
      int unsigned                  b;
      int unsigned                  d;
      logic signed [SAMPLE_BITS-1:0] r;
      b = (bnd > MAX_BOUND) ? MAX_BOUND : bnd;
      r = s;
      if (p < b) r = scale_by(r, taper_mem[ax][p]);
      // a position left beyond a shrunken size has no high face
      if (p < sz) begin
         d = sz - 1 - p;
         if (d < b) r = scale_by(r, taper_mem[ax][d]);
      end
      return r;
   endfunction

   function automatic void record_request(input taper_req_type r, input logic typed_exp,
                                          input taper_res_type typed_res);
      logic signed [SAMPLE_BITS-1:0] s;
      taper_res_type                 res;
      if (r.op == OP_LOAD) begin
         if (r.axis != AXIS_NONE) taper_mem[r.axis][r.idx] = r.word;
         return;
      end
      s = r.smp;
      s = taper_one_axis(s, AXIS_Y, pos_y, eff_dim(cfg_reg[REG_SIZE_Y]), cfg_reg[REG_BOUND_Y]);
      s = taper_one_axis(s, AXIS_X, pos_x, eff_dim(cfg_reg[REG_SIZE_X]), cfg_reg[REG_BOUND_X]);
      s = taper_one_axis(s, AXIS_Z, pos_z, eff_dim(cfg_reg[REG_SIZE_Z]), cfg_reg[REG_BOUND_Z]);
      res.smp  = s;
      res.last = 1'b0;
      // advance z fastest; wrapping all three closes the volume
      if (pos_z + 1 < eff_dim(cfg_reg[REG_SIZE_Z])) begin
         pos_z++;
      end else begin
         pos_z = 0;
         if (pos_x + 1 < eff_dim(cfg_reg[REG_SIZE_X])) begin
            pos_x++;
         end else begin
            pos_x = 0;
            if (pos_y + 1 < eff_dim(cfg_reg[REG_SIZE_Y])) begin
               pos_y++;
            end else begin
               pos_y = 0;
               res.last = 1'b1;
            end
         end
      end
      pending_samples.push_back(typed_exp ? typed_res : res);
   endfunction

   function automatic int sender_pause_pct();
      case (idle_mode)
         IDLE_SENDER: return 47;
         IDLE_BOTH:   return 28;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 47;
         IDLE_BOTH:     return 28;
         default:       return 0;
      endcase
   endfunction

   function automatic stim_row_type sample_row(input logic [SAMPLE_BITS-1:0] smp,
                                               input logic typed_exp,
                                               input logic [SAMPLE_BITS-1:0] exp_smp,
                                               input logic exp_last);
      stim_row_type row;
      row.kind      = ROW_REQ;
      row.req       = '0;
      row.req.op    = OP_SAMPLE;
      row.req.smp   = smp;
      row.typed_exp = typed_exp;
      row.res.smp   = exp_smp;
      row.res.last  = exp_last;
      row.csr_idx   = '0;
      row.csr_val   = '0;
      return row;
   endfunction

   function automatic stim_row_type load_row(input logic [AXIS_BITS-1:0] axis,
                                             input logic [IDX_BITS-1:0] idx,
                                             input logic [TAPER_BITS-1:0] word);
      stim_row_type row;
      row.kind      = ROW_REQ;
      row.req.op    = OP_LOAD;
      row.req.axis  = axis;
      row.req.idx   = idx;
      row.req.word  = word;
      row.req.smp   = SAMPLE_BITS'($urandom);
      row.typed_exp = 1'b0;
      row.res       = '0;
      row.csr_idx   = '0;
      row.csr_val   = '0;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_BITS-1:0] idx,
                                            input logic [SIZE_BITS-1:0] val);
      stim_row_type row;
      row.kind      = ROW_CSR;
      row.req       = '0;
      row.typed_exp = 1'b0;
      row.res       = '0;
      row.csr_idx   = idx;
      row.csr_val   = val;
      return row;
   endfunction

   task automatic send_req(input taper_req_type r, input logic typed_exp,
                           input taper_res_type typed_res);
      while ($urandom_range(99) < sender_pause_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.smp, r.word, r.idx};
      req_tuser  <= {r.axis, r.op};
      do @(posedge clock); while (!req_tready);
      req_moved = 1'b1;
      record_request(r, typed_exp, typed_res);
   endtask

   // drop the request valid, wait for every result, then let table loads finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      req_moved = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] val);
      if (req_moved) settle_block();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cfg_reg[idx] = val & ((idx < REG_BOUND_X) ? ((1 << SIZE_BITS) - 1) : ((1 << BOUND_BITS) - 1));
   endtask

   initial begin
      stim_row_type  dir_rows [$];
      taper_req_type r;
      taper_res_type no_res;
      cfg_reg = '{1, 1, 1, 0, 0, 0};
      pos_x   = 0;
      pos_y   = 0;
      pos_z   = 0;
      no_res  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // write every table entry first so that no read finds one unwritten
      for (int ax = 0; ax < 3; ax++) begin
         for (int i = 0; i < MAX_BOUND; i++) begin
            r.op   = OP_LOAD;
            r.axis = AXIS_BITS'(ax);
            r.idx  = IDX_BITS'(i);
            r.word = TAPER_BITS'($urandom_range(0, 32768));
            r.smp  = SAMPLE_BITS'($urandom);
            send_req(r, 1'b0, no_res);
         end
      end

      // reset settings: one sample per volume, no taper, so samples pass unchanged
      dir_rows.push_back(sample_row('0, 1'b1, '0, 1'b1));
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b1));
      dir_rows.push_back(sample_row(24'h000001, 1'b1, 24'h000001, 1'b1));
      dir_rows.push_back(sample_row(24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1));
      dir_rows.push_back(load_row(AXIS_X, '0, TAPER_ONE));
      dir_rows.push_back(load_row(AXIS_Y, '0, 16'hFFFF));
      dir_rows.push_back(load_row(AXIS_Z, '0, 16'h0000));
      dir_rows.push_back(load_row(AXIS_Z, IDX_BITS'(MAX_BOUND - 1), 16'h4000));
      // the unused axis code must leave every table alone
      dir_rows.push_back(load_row(AXIS_NONE, '0, 16'h1234));
      // bounds past half the size: faces overlap, odd midpoints taper twice
      dir_rows.push_back(csr_row(REG_SIZE_X, 13'd3));
      dir_rows.push_back(csr_row(REG_SIZE_Y, 13'd1));
      dir_rows.push_back(csr_row(REG_SIZE_Z, 13'd5));
      dir_rows.push_back(csr_row(REG_BOUND_X, 13'd2));
      dir_rows.push_back(csr_row(REG_BOUND_Y, 13'd127));
      dir_rows.push_back(csr_row(REG_BOUND_Z, 13'd3));
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'h000005, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'hFFFFFB, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'h004000, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'hFFBFFF, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'h2AAAAA, 1'b0, '0, 1'b0));
      dir_rows.push_back(sample_row(24'h555555, 1'b0, '0, 1'b0));

      idle_mode <= IDLE_BOTH;
      foreach (dir_rows[k]) begin
         if (dir_rows[k].kind == ROW_CSR) begin
            write_reg(dir_rows[k].csr_idx, dir_rows[k].csr_val);
         end else begin
            send_req(dir_rows[k].req, dir_rows[k].typed_exp, dir_rows[k].res);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            write_reg(CSR_IDX_BITS'(k), SIZE_BITS'(phase_cfg[ph][k]));
         end
         idle_mode <= idle_mode_type'(ph % 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off the receiver for a long stretch so the block backs up
            if (ph == HOLD_PHASE && n == 8) hold_go <= 1'b1;
            r.axis = AXIS_BITS'($urandom_range(0, 3));
            r.idx  = IDX_BITS'($urandom);
            if ($urandom_range(7) == 0) r.word = TAPER_BITS'($urandom);
            else if ($urandom_range(3) == 0) r.word = TAPER_ONE;
            else r.word = TAPER_BITS'($urandom_range(0, 32768));
            case ($urandom_range(9))
               0:       r.smp = SAMPLE_MAX;
               1:       r.smp = SAMPLE_MIN;
               2:       r.smp = SAMPLE_BITS'($urandom_range(0, 64) - 32);
               default: r.smp = SAMPLE_BITS'($urandom);
            endcase
            r.op = ($urandom_range(9) == 0) ? OP_LOAD : OP_SAMPLE;
            send_req(r, 1'b0, no_res);
         end
      end

      settle_block();
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      taper_res_type got;
      taper_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.smp  = rsp_tdata;
            got.last = rsp_tlast;
            if (pending_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: sample %h last %b", got.smp, got.last);
            end else begin
               want = pending_samples.pop_front();
               if (got.smp !== want.smp || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result mismatch: sample %h last %b, expected sample %h last %b",
                              got.smp, got.last, want.smp, want.last);
               end
            end
         end
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
         end
      end
   end

   // end the run once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: volume_boundary_taper.f
sv/vbt_pkg.sv
sv/vbt_scale.sv
sv/volume_boundary_taper.sv
dv/tb_top.sv
